### rtl/core/tfe_pkg.sv
// Shared types, constants and frame field lookups for the telemetry frame encoder.
package tfe_pkg;

   localparam int WORD_COUNT = 6;
   localparam int WORD_WIDTH = 16;
   localparam int BYTE_WIDTH = 8;
   localparam int CNT_WIDTH  = 4;
   localparam int CSR_WIDTH  = 16;
   localparam int IDX_WIDTH  = 2;

   localparam logic [BYTE_WIDTH-1:0] FRAME_HEADER = 8'hAA;

   localparam logic [1:0] KIND_INERTIAL = 2'd0;
   localparam logic [1:0] KIND_EULER    = 2'd1;
   localparam logic [1:0] KIND_QUAT     = 2'd2;
   localparam logic [1:0] KIND_NONE     = 2'd3;

   localparam logic [BYTE_WIDTH-1:0] FUNC_INERTIAL = 8'h01;
   localparam logic [BYTE_WIDTH-1:0] FUNC_EULER    = 8'h03;
   localparam logic [BYTE_WIDTH-1:0] FUNC_QUAT     = 8'h04;

   localparam logic [BYTE_WIDTH-1:0] LEN_INERTIAL = 8'd13;
   localparam logic [BYTE_WIDTH-1:0] LEN_EULER    = 8'd7;
   localparam logic [BYTE_WIDTH-1:0] LEN_QUAT     = 8'd9;

   localparam logic [IDX_WIDTH-1:0] REG_TARGET_ADDRESS = 2'd0;
   localparam logic [IDX_WIDTH-1:0] REG_EULER_SCALE    = 2'd1;
   localparam logic [IDX_WIDTH-1:0] REG_QUAT_SCALE     = 2'd2;

   localparam logic [BYTE_WIDTH-1:0] RESET_TARGET_ADDRESS = 8'hFF;
   localparam logic [WORD_WIDTH-1:0] RESET_EULER_SCALE    = 16'd100;
   localparam logic [WORD_WIDTH-1:0] RESET_QUAT_SCALE     = 16'd10000;

   typedef logic [WORD_COUNT-1:0][WORD_WIDTH-1:0] word_array_type;

   typedef struct packed {
      logic load;
      logic fetch;
      logic shift;
      logic use_scale;
   } scaler_ctl_type;

   typedef struct packed {
      logic clear;
      logic update;
   } check_ctl_type;

   function automatic logic [BYTE_WIDTH-1:0] func_code(input logic [1:0] kind);
      logic [BYTE_WIDTH-1:0] code;
      unique case (kind)
         KIND_EULER: code = FUNC_EULER;
         KIND_QUAT:  code = FUNC_QUAT;
         default:    code = FUNC_INERTIAL;
      endcase
      return code;
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] frame_len(input logic [1:0] kind);
      logic [BYTE_WIDTH-1:0] len;
      unique case (kind)
         KIND_EULER: len = LEN_EULER;
         KIND_QUAT:  len = LEN_QUAT;
         default:    len = LEN_INERTIAL;
      endcase
      return len;
   endfunction

   // index of the last payload byte: twice the word count, minus one
   function automatic logic [CNT_WIDTH-1:0] body_last(input logic [1:0] kind);
      logic [BYTE_WIDTH-1:0] len;
      len = frame_len(kind);
      return len[CNT_WIDTH-1:0] - CNT_WIDTH'(2);
   endfunction

endpackage

### rtl/core/tfe_scaler.sv
// Payload word store, 16-bit scale multiplier and byte shifter.
module tfe_scaler (
   input  logic                                    clock,
   input  tfe_pkg::scaler_ctl_type                 ctl,
   input  tfe_pkg::word_array_type                 words,
   input  logic [tfe_pkg::WORD_WIDTH-1:0]          scale,
   output logic [tfe_pkg::BYTE_WIDTH-1:0]          payload_byte
);

   tfe_pkg::word_array_type              raw_ff;
   logic [tfe_pkg::WORD_WIDTH-1:0]       scale_ff;
   logic                                 use_scale_ff;
   logic [tfe_pkg::WORD_WIDTH-1:0]       word_ff;
   logic [2*tfe_pkg::WORD_WIDTH-1:0]     product;
   logic [tfe_pkg::WORD_WIDTH-1:0]       word_in;

   assign product      = raw_ff[0] * scale_ff;
   assign word_in      = use_scale_ff ? product[tfe_pkg::WORD_WIDTH-1:0] : raw_ff[0];
   assign payload_byte = word_ff[tfe_pkg::BYTE_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         raw_ff       <= words;
         scale_ff     <= scale;
         use_scale_ff <= ctl.use_scale;
      end else if (ctl.fetch) begin
         for (int i = 0; i < tfe_pkg::WORD_COUNT - 1; i++) begin
            raw_ff[i] <= raw_ff[i+1];
         end
         raw_ff[tfe_pkg::WORD_COUNT-1] <= '0;
      end

      if (ctl.fetch) begin
         word_ff <= word_in;
      end else if (ctl.shift) begin
         word_ff <= {{tfe_pkg::BYTE_WIDTH{1'b0}},
                     word_ff[tfe_pkg::WORD_WIDTH-1:tfe_pkg::BYTE_WIDTH]};
      end
   end

endmodule

### rtl/core/tfe_check.sv
// Running sum check and add check, one byte per cycle while ctl.update is set.
module tfe_check (
   input  logic                             clock,
   input  tfe_pkg::check_ctl_type           ctl,
   input  logic [tfe_pkg::BYTE_WIDTH-1:0]   data_byte,
   output logic [tfe_pkg::BYTE_WIDTH-1:0]   sum_total,
   output logic [tfe_pkg::BYTE_WIDTH-1:0]   add_total
);

   logic [tfe_pkg::BYTE_WIDTH-1:0] sum_ff;
   logic [tfe_pkg::BYTE_WIDTH-1:0] add_ff;
   logic [tfe_pkg::BYTE_WIDTH-1:0] sum_in;
   logic [tfe_pkg::BYTE_WIDTH-1:0] add_in;

   assign sum_in    = sum_ff + data_byte;
   assign add_in    = add_ff + sum_in;
   assign sum_total = sum_ff;
   assign add_total = add_ff;

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         sum_ff <= '0;
         add_ff <= '0;
      end else if (ctl.update) begin
         sum_ff <= sum_in;
         add_ff <= add_in;
      end
   end

endmodule

### rtl/core/telemetry_frame_encoder.sv
// Top level of the telemetry frame encoder: frame sequencer, registers and output stage.
//
// One request item carries a record kind, six signed 16-bit values and a status
// byte. The block answers with one frame, one byte per response item:
// header, target address, function code, length, payload words low byte first,
// status, sum check and add check; rsp_last_byte marks the add check byte.
// Inertial frames have 19 bytes, Euler frames 13 and quaternion frames 15.
// A request of kind 3 is taken and answered with nothing.
// After a request is taken the frame leaves one byte per cycle while rsp_stall stays
// low. Scaled words go through one 16x16 multiplier, one word per two bytes sent.
// req_stall is high while a frame is being sent; the next request is taken
// in the cycle after the last byte enters the output register.
// With rsp_valid and rsp_stall high, the output byte holds and the sequencer waits.
// Reset clears the sequencer and output valid and loads the default target
// address (0xFF), Euler scale (100) and quaternion scale (10000). CSR writes take
// effect at the next clock edge; the user must make them while idle (not enforced).
module telemetry_frame_encoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [tfe_pkg::IDX_WIDTH-1:0]         csr_index,
   input  logic [tfe_pkg::CSR_WIDTH-1:0]         csr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_kind,
   input  logic signed [tfe_pkg::WORD_WIDTH-1:0] req_value_0,
   input  logic signed [tfe_pkg::WORD_WIDTH-1:0] req_value_1,
   input  logic signed [tfe_pkg::WORD_WIDTH-1:0] req_value_2,
   input  logic signed [tfe_pkg::WORD_WIDTH-1:0] req_value_3,
   input  logic signed [tfe_pkg::WORD_WIDTH-1:0] req_value_4,
   input  logic signed [tfe_pkg::WORD_WIDTH-1:0] req_value_5,
   input  logic [tfe_pkg::BYTE_WIDTH-1:0]        req_status,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tfe_pkg::BYTE_WIDTH-1:0]        rsp_tx_byte,
   output logic                                  rsp_last_byte
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_BODY,
      ST_STAT,
      ST_SUM,
      ST_ADD
   } state_type;

   state_type                              state_ff, state_in;
   logic [tfe_pkg::CNT_WIDTH-1:0]          cnt_ff, cnt_in;
   logic [1:0]                             kind_ff, kind_in;
   logic [tfe_pkg::BYTE_WIDTH-1:0]         status_ff, status_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [tfe_pkg::BYTE_WIDTH-1:0]         rsp_tx_byte_ff, rsp_tx_byte_in;
   logic                                   rsp_last_byte_ff, rsp_last_byte_in;

   logic [tfe_pkg::BYTE_WIDTH-1:0]         target_address_ff;
   logic [tfe_pkg::WORD_WIDTH-1:0]         euler_scale_ff;
   logic [tfe_pkg::WORD_WIDTH-1:0]         quat_scale_ff;

   logic                                   req_accept;
   logic                                   advance;
   logic [tfe_pkg::BYTE_WIDTH-1:0]         next_byte;
   logic [tfe_pkg::BYTE_WIDTH-1:0]         payload_byte;
   logic [tfe_pkg::BYTE_WIDTH-1:0]         sum_total;
   logic [tfe_pkg::BYTE_WIDTH-1:0]         add_total;
   logic [tfe_pkg::WORD_WIDTH-1:0]         scale_sel;
   tfe_pkg::word_array_type                words;
   tfe_pkg::scaler_ctl_type                scaler_ctl;
   tfe_pkg::check_ctl_type                 check_ctl;

   assign req_stall     = (state_ff != ST_IDLE);
   assign req_accept    = req_valid && !req_stall;
   assign advance       = (state_ff != ST_IDLE) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tx_byte   = rsp_tx_byte_ff;
   assign rsp_last_byte = rsp_last_byte_ff;

   assign words = {req_value_5, req_value_4, req_value_3,
                   req_value_2, req_value_1, req_value_0};
   assign scale_sel = (req_kind == tfe_pkg::KIND_QUAT) ? quat_scale_ff : euler_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_address_ff <= tfe_pkg::RESET_TARGET_ADDRESS;
         euler_scale_ff    <= tfe_pkg::RESET_EULER_SCALE;
         quat_scale_ff     <= tfe_pkg::RESET_QUAT_SCALE;
      end else if (csr_write) begin
         unique case (csr_index)
            tfe_pkg::REG_TARGET_ADDRESS: begin
               target_address_ff <= csr_data[tfe_pkg::BYTE_WIDTH-1:0];
            end
            tfe_pkg::REG_EULER_SCALE: begin
               euler_scale_ff <= csr_data;
            end
            tfe_pkg::REG_QUAT_SCALE: begin
               quat_scale_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // select the byte that the sequencer sends next
   always_comb begin
      next_byte = '0;
      unique case (state_ff)
         ST_HEAD: begin
            unique case (cnt_ff[1:0])
               2'd0:    next_byte = tfe_pkg::FRAME_HEADER;
               2'd1:    next_byte = target_address_ff;
               2'd2:    next_byte = tfe_pkg::func_code(kind_ff);
               default: next_byte = tfe_pkg::frame_len(kind_ff);
            endcase
         end
         ST_BODY: next_byte = payload_byte;
         ST_STAT: next_byte = status_ff;
         ST_SUM:  next_byte = sum_total;
         ST_ADD:  next_byte = add_total;
         default: next_byte = '0;
      endcase
   end

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      kind_in          = kind_ff;
      status_in        = status_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_tx_byte_in   = rsp_tx_byte_ff;
      rsp_last_byte_in = rsp_last_byte_ff;

      scaler_ctl.load      = req_accept;
      scaler_ctl.fetch     = 1'b0;
      scaler_ctl.shift     = 1'b0;
      scaler_ctl.use_scale = (req_kind != tfe_pkg::KIND_INERTIAL);
      check_ctl.clear      = req_accept;
      check_ctl.update     = 1'b0;

      if (req_accept) begin
         kind_in   = req_kind;
         status_in = (req_kind == tfe_pkg::KIND_INERTIAL) ? '0 : req_status;
         cnt_in    = '0;
         if (req_kind != tfe_pkg::KIND_NONE) begin
            state_in = ST_HEAD;
         end
      end

      if (advance) begin
         rsp_valid_in     = 1'b1;
         rsp_tx_byte_in   = next_byte;
         rsp_last_byte_in = (state_ff == ST_ADD);
         unique case (state_ff)
            ST_HEAD: begin
               check_ctl.update = 1'b1;
               cnt_in           = cnt_ff + 1'b1;
               if (cnt_ff[1:0] == 2'd3) begin
                  scaler_ctl.fetch = 1'b1;
                  cnt_in           = '0;
                  state_in         = ST_BODY;
               end
            end
            ST_BODY: begin
               check_ctl.update = 1'b1;
               cnt_in           = cnt_ff + 1'b1;
               if (cnt_ff[0]) begin
                  scaler_ctl.fetch = 1'b1;
               end else begin
                  scaler_ctl.shift = 1'b1;
               end
               if (cnt_ff == tfe_pkg::body_last(kind_ff)) begin
                  state_in = ST_STAT;
               end
            end
            ST_STAT: begin
               check_ctl.update = 1'b1;
               state_in         = ST_SUM;
            end
            ST_SUM: begin
               state_in = ST_ADD;
            end
            ST_ADD: begin
               state_in = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff          <= kind_in;
      status_ff        <= status_in;
      rsp_tx_byte_ff   <= rsp_tx_byte_in;
      rsp_last_byte_ff <= rsp_last_byte_in;
   end

   tfe_scaler u_scaler (
      .clock        (clock),
      .ctl          (scaler_ctl),
      .words        (words),
      .scale        (scale_sel),
      .payload_byte (payload_byte)
   );

   tfe_check u_check (
      .clock     (clock),
      .ctl       (check_ctl),
      .data_byte (next_byte),
      .sum_total (sum_total),
      .add_total (add_total)
   );

endmodule

### rtl/core/tfe_checker.sv
// Port-level assertions for the telemetry frame encoder, bound to the top level.
module tfe_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic [1:0]                            req_kind,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [tfe_pkg::BYTE_WIDTH-1:0]        rsp_tx_byte,
   input  logic                                  rsp_last_byte
);

   logic req_accept;

   assign req_accept = req_valid && !req_stall;

   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("outputs not idle after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_last_byte))
      else $error("stalled response item changed");

   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_kind != tfe_pkg::KIND_NONE) |=> req_stall)
      else $error("frame start did not hold off requests");

   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_kind == tfe_pkg::KIND_NONE) |=> !req_stall)
      else $error("empty request left the encoder busy");

endmodule

bind telemetry_frame_encoder tfe_checker u_tfe_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_kind      (req_kind),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_tx_byte   (rsp_tx_byte),
   .rsp_last_byte (rsp_last_byte)
);

### sim/tfe_frame_checker.sv
// Frame byte predictor and scoreboard for the telemetry frame encoder.
module tfe_frame_checker
   import tfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_WIDTH-1:0]  csr_data,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [1:0]            req_kind,
   input  logic [WORD_WIDTH-1:0] req_value_0,
   input  logic [WORD_WIDTH-1:0] req_value_1,
   input  logic [WORD_WIDTH-1:0] req_value_2,
   input  logic [WORD_WIDTH-1:0] req_value_3,
   input  logic [WORD_WIDTH-1:0] req_value_4,
   input  logic [WORD_WIDTH-1:0] req_value_5,
   input  logic [BYTE_WIDTH-1:0] req_status,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [BYTE_WIDTH-1:0] rsp_tx_byte,
   input  logic                  rsp_last_byte,
   output int                    mismatches,
   output int                    bytes_due
);

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] tx_byte;
      logic                  last_byte;
   } frame_byte_type;

   frame_byte_type        due_q[$];
   logic [BYTE_WIDTH-1:0] target_addr;
   logic [WORD_WIDTH-1:0] euler_scale;
   logic [WORD_WIDTH-1:0] quat_scale;

   function automatic void flag(input string msg);
      if (mismatches < 10) begin
         $display("%s", msg);
      end
      mismatches++;
   endfunction

   // queue every byte of the frame that one record produces
   function automatic void push_frame(input logic [1:0] kind, input word_array_type vals,
                                      input logic [BYTE_WIDTH-1:0] status);
      logic [BYTE_WIDTH-1:0] frame[$];
      logic [BYTE_WIDTH-1:0] func;
      logic [BYTE_WIDTH-1:0] len;
      logic [BYTE_WIDTH-1:0] stat;
      logic [BYTE_WIDTH-1:0] sum;
      logic [BYTE_WIDTH-1:0] add;
      logic [WORD_WIDTH-1:0] scale;
      logic [WORD_WIDTH-1:0] prod;
      frame_byte_type        fb;
      int                    nwords;
      case (kind)
         KIND_INERTIAL: begin
            nwords = 6;
            func   = FUNC_INERTIAL;
            len    = LEN_INERTIAL;
            stat   = '0;
            scale  = 16'd1;
         end
         KIND_EULER: begin
            nwords = 3;
            func   = FUNC_EULER;
            len    = LEN_EULER;
            stat   = status;
            scale  = euler_scale;
         end
         KIND_QUAT: begin
            nwords = 4;
            func   = FUNC_QUAT;
            len    = LEN_QUAT;
            stat   = status;
            scale  = quat_scale;
         end
         default: begin
            return;
         end
      endcase
      frame.push_back(FRAME_HEADER);
      frame.push_back(target_addr);
      frame.push_back(func);
      frame.push_back(len);
      for (int i = 0; i < nwords; i++) begin
         prod = vals[i] * scale;
         frame.push_back(prod[7:0]);
         frame.push_back(prod[15:8]);
      end
      frame.push_back(stat);
      sum = '0;
      add = '0;
      foreach (frame[i]) begin
         sum = sum + frame[i];
         add = add + sum;
      end
      frame.push_back(sum);
      frame.push_back(add);
      foreach (frame[i]) begin
         fb.tx_byte   = frame[i];
         fb.last_byte = (i == frame.size() - 1);
         due_q.push_back(fb);
      end
   endfunction

   always @(posedge clock) begin : watch
      frame_byte_type want;
      if (reset) begin
         target_addr = RESET_TARGET_ADDRESS;
         euler_scale = RESET_EULER_SCALE;
         quat_scale  = RESET_QUAT_SCALE;
         due_q.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_TARGET_ADDRESS: target_addr = csr_data[BYTE_WIDTH-1:0];
               REG_EULER_SCALE:    euler_scale = csr_data;
               REG_QUAT_SCALE:     quat_scale  = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_q.size() == 0) begin
               flag($sformatf("unexpected byte: tx %02h last %0d", rsp_tx_byte, rsp_last_byte));
            end else begin
               want = due_q.pop_front();
               if (want.tx_byte !== rsp_tx_byte || want.last_byte !== rsp_last_byte) begin
                  flag($sformatf("byte mismatch: expected tx %02h last %0d, got tx %02h last %0d",
                                 want.tx_byte, want.last_byte, rsp_tx_byte, rsp_last_byte));
               end
            end
         end
         if (req_valid && !req_stall) begin
            push_frame(req_kind, {req_value_5, req_value_4, req_value_3,
                                  req_value_2, req_value_1, req_value_0}, req_status);
         end
      end
      bytes_due = due_q.size();
   end

endmodule

### sim/tb.sv
// Stimulus, flow control and verdict for the telemetry frame encoder testbench.
module tb;
   import tfe_pkg::*;

   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 200000;

   logic                  clock;
   logic                  reset;
   logic                  csr_write;
   logic [IDX_WIDTH-1:0]  csr_index;
   logic [CSR_WIDTH-1:0]  csr_data;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_kind;
   logic [WORD_WIDTH-1:0] req_value_0;
   logic [WORD_WIDTH-1:0] req_value_1;
   logic [WORD_WIDTH-1:0] req_value_2;
   logic [WORD_WIDTH-1:0] req_value_3;
   logic [WORD_WIDTH-1:0] req_value_4;
   logic [WORD_WIDTH-1:0] req_value_5;
   logic [BYTE_WIDTH-1:0] req_status;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [BYTE_WIDTH-1:0] rsp_tx_byte;
   logic                  rsp_last_byte;

   int   send_idle_pct;
   int   recv_idle_pct;
   logic long_hold_req;
   int   cycle_count;
   int   mismatches;
   int   bytes_due;

   telemetry_frame_encoder u_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_value_0   (req_value_0),
      .req_value_1   (req_value_1),
      .req_value_2   (req_value_2),
      .req_value_3   (req_value_3),
      .req_value_4   (req_value_4),
      .req_value_5   (req_value_5),
      .req_status    (req_status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last_byte (rsp_last_byte)
   );

   tfe_frame_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_value_0   (req_value_0),
      .req_value_1   (req_value_1),
      .req_value_2   (req_value_2),
      .req_value_3   (req_value_3),
      .req_value_4   (req_value_4),
      .req_value_5   (req_value_5),
      .req_status    (req_status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last_byte (rsp_last_byte),
      .mismatches    (mismatches),
      .bytes_due     (bytes_due)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin : receiver
      int  hold_left;
      bit  hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   function automatic logic [WORD_WIDTH-1:0] rand_word();
      case ($urandom_range(0, 7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'hFFFF;
         default: return WORD_WIDTH'($urandom);
      endcase
   endfunction

   // offer one item and hold it until accepted; returns at a falling edge
   task automatic send_item(input logic [1:0] kind, input word_array_type vals,
                            input logic [BYTE_WIDTH-1:0] status);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_kind    = kind;
      req_value_0 = vals[0];
      req_value_1 = vals[1];
      req_value_2 = vals[2];
      req_value_3 = vals[3];
      req_value_4 = vals[4];
      req_value_5 = vals[5];
      req_status  = status;
      req_valid   = 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [1:0]     kind;
      word_array_type vals;
      case ($urandom_range(0, 9))
         0, 1, 2: kind = KIND_INERTIAL;
         3, 4, 5: kind = KIND_EULER;
         6, 7, 8: kind = KIND_QUAT;
         default: kind = KIND_NONE;
      endcase
      for (int i = 0; i < WORD_COUNT; i++) begin
         vals[i] = rand_word();
      end
      send_item(kind, vals, BYTE_WIDTH'($urandom));
   endtask

   // drain the block, then load all three registers
   task automatic reconfigure(input logic [CSR_WIDTH-1:0] addr,
                              input logic [CSR_WIDTH-1:0] escale,
                              input logic [CSR_WIDTH-1:0] qscale);
      req_valid = 1'b0;
      wait (bytes_due == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write = 1'b1;
      csr_index = REG_TARGET_ADDRESS;
      csr_data  = addr;
      @(negedge clock);
      csr_index = REG_EULER_SCALE;
      csr_data  = escale;
      @(negedge clock);
      csr_index = REG_QUAT_SCALE;
      csr_data  = qscale;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   initial begin : stimulus
      reset         = 1'b1;
      csr_write     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      req_valid     = 1'b0;
      req_kind      = '0;
      req_value_0   = '0;
      req_value_1   = '0;
      req_value_2   = '0;
      req_value_3   = '0;
      req_value_4   = '0;
      req_value_5   = '0;
      req_status    = '0;
      long_hold_req = 1'b0;
      send_idle_pct = 36;
      recv_idle_pct = 57;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // reset register values
      send_item(KIND_INERTIAL, {6{16'h7FFF}}, 8'hFF);
      send_item(KIND_INERTIAL, {6{16'h8000}}, 8'h5A);
      send_item(KIND_INERTIAL, {16'h1234, 16'h7FFF, 16'h8000, 16'h0001, 16'h0000, 16'hFFFF}, 8'h00);
      send_item(KIND_EULER, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF}, 8'hFF);
      send_item(KIND_EULER, {16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000}, 8'h00);
      send_item(KIND_QUAT, {16'h5555, 16'hAAAA, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF}, 8'h80);
      send_item(KIND_QUAT, {6{16'h0000}}, 8'h01);
      send_item(KIND_NONE, {6{16'hFFFF}}, 8'hFF);
      send_item(KIND_NONE, {6{16'h0000}}, 8'h00);
      send_item(KIND_INERTIAL, {6{16'h0000}}, 8'h00);

      reconfigure(16'h0000, 16'hFFFF, 16'hFFFF);
      send_item(KIND_EULER, {16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF}, 8'hAA);
      send_item(KIND_QUAT, {16'h0000, 16'h0000, 16'h0002, 16'hFFFF, 16'h8000, 16'h7FFF}, 8'h55);
      send_item(KIND_INERTIAL, {6{16'hAAAA}}, 8'h33);

      reconfigure(16'hFFFF, 16'h0000, 16'h0000);
      send_item(KIND_EULER, {16'h1111, 16'h2222, 16'h3333, 16'hFFFF, 16'h8000, 16'h7FFF}, 8'h7F);
      send_item(KIND_QUAT, {16'h0000, 16'h0000, 16'h8000, 16'hFFFF, 16'h8000, 16'h7FFF}, 8'hFE);
      send_item(KIND_NONE, {6{16'h5555}}, 8'h0F);
      send_item(KIND_EULER, {16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h7FFF, 16'h8000}, 8'hF0);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 36;
               recv_idle_pct = 57;
            end
            1: begin
               send_idle_pct = 57;
               recv_idle_pct = 36;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         reconfigure(CSR_WIDTH'($urandom), CSR_WIDTH'($urandom), CSR_WIDTH'($urandom));
         for (int n = 0; n < 34; n++) begin
            if (phase == 0 && n == 10) begin
               long_hold_req = 1'b1;
            end
            send_random();
         end
      end

      req_valid = 1'b0;
      wait (bytes_due == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
